// ----- src/bta_pkg.sv -----
package bta_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int MAX_DIGITS  = VALUE_WIDTH;
    localparam int DIG_AW      = $clog2(MAX_DIGITS);
    localparam int COUNT_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // x / 10 == (x * DIV10_RECIP) >> DIV10_SHIFT for any 32-bit x
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    localparam logic [1:0] SEL_DEC = 2'd0;
    localparam logic [1:0] SEL_HEX = 2'd1;
    localparam logic [1:0] SEL_BIN = 2'd2;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } t_radix;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        t_radix                 radix;
    } t_item;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = 7'd48 + CHAR_W'(d);
        end else begin
            c = 7'd55 + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ----- src/binary_to_ascii_radix.sv -----
// Binary to ASCII conversion, radix 10, 16 or 2.
// Input channel (i_in_valid / o_in_ready): one request carries a 32-bit
// unsigned value and a radix select (0 decimal, 1 hex, 2 binary). Select 3
// is accepted and dropped with no output.
// Output channel (o_out_valid / i_out_ready): one request per digit, most
// significant first, upper-case ASCII, leading zeros suppressed; zero gives
// a single '0'. Each carries the total digit count; the final digit has
// o_last_digit set.
// A request passes an input register and a two-entry queue, then a
// converter that extracts one digit per cycle (divide by 10 through a
// reciprocal multiply, or a shift for hex and binary) and then emits one
// digit per cycle from its digit store while the receiver is ready.
// The converter handles one value at a time: it takes the next value from
// the queue only after it has issued the last digit of the current one.
// Reset (synchronous, active low) empties the queue and the converter.
// When the receiver stalls, the output request holds and the converter
// waits; the queue then fills and o_in_ready drops.
module binary_to_ascii_radix (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [31:0]                  i_value,
    input  logic [1:0]                   i_radix_select,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [bta_pkg::CHAR_W-1:0]   o_digit_char,
    output logic [bta_pkg::COUNT_W-1:0]  o_digit_count,
    output logic                         o_last_digit
);
    import bta_pkg::*;

    t_item fr_item, q_item;
    logic  push, full, pop, empty;

    bta_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_value        (i_value),
        .i_radix_select (i_radix_select),
        .i_full         (full),
        .o_push         (push),
        .o_item         (fr_item)
    );

    bta_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fr_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (q_item)
    );

    bta_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_item        (q_item),
        .o_pop         (pop),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_digit_char  (o_digit_char),
        .o_digit_count (o_digit_count),
        .o_last_digit  (o_last_digit)
    );

endmodule

// ----- src/bta_front.sv -----
module bta_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [31:0]   i_value,
    input  logic [1:0]    i_radix_select,
    input  logic          i_full,
    output logic          o_push,
    output bta_pkg::t_item o_item
);
    import bta_pkg::*;

    logic   r_valid, n_valid;
    t_item  r_item;
    t_item  dec_item;
    logic   keep;
    logic   accept;

    always_comb begin
        dec_item.value = i_value[VALUE_WIDTH-1:0];
        dec_item.radix = RADIX_DEC;
        keep           = 1'b1;
        unique case (i_radix_select)
            SEL_DEC: dec_item.radix = RADIX_DEC;
            SEL_HEX: dec_item.radix = RADIX_HEX;
            SEL_BIN: dec_item.radix = RADIX_BIN;
            default: keep = 1'b0;
        endcase
    end

    assign o_push  = r_valid && !i_full;
    assign o_ready = !r_valid || !i_full;
    assign accept  = i_valid && o_ready;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid && !o_push;
        if (accept) begin
            n_valid = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= dec_item;
        end
    end

endmodule

// ----- src/bta_queue.sv -----
module bta_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bta_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bta_pkg::t_item o_item
);
    import bta_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ----- src/bta_back.sv -----
module bta_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  bta_pkg::t_item               i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bta_pkg::CHAR_W-1:0]   o_digit_char,
    output logic [bta_pkg::COUNT_W-1:0]  o_digit_count,
    output logic                         o_last_digit
);
    import bta_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [VALUE_WIDTH-1:0]  r_x, n_x;
    t_radix                  r_radix;
    logic [3:0]              r_dig [MAX_DIGITS];
    logic [COUNT_W-1:0]      r_cnt;
    logic [DIG_AW-1:0]       r_idx;
    logic                    r_ovalid;
    logic [CHAR_W-1:0]       r_ochar;
    logic [COUNT_W-1:0]      r_ocount;
    logic                    r_olast;

    logic [2*VALUE_WIDTH-1:0] prod;
    logic [VALUE_WIDTH-1:0]   quot10, q_times10;
    logic [3:0]               digit;
    logic                     slot_free;

    assign prod      = (2*VALUE_WIDTH)'(r_x) * (2*VALUE_WIDTH)'(DIV10_RECIP);
    assign quot10    = VALUE_WIDTH'(prod >> DIV10_SHIFT);
    assign q_times10 = (quot10 << 3) + (quot10 << 1);

    always_comb begin
        unique case (r_radix)
            RADIX_HEX: begin
                digit = r_x[3:0];
                n_x   = r_x >> 4;
            end
            RADIX_BIN: begin
                digit = {3'b000, r_x[0]};
                n_x   = r_x >> 1;
            end
            default: begin
                digit = r_x[3:0] - q_times10[3:0];
                n_x   = quot10;
            end
        endcase
    end

    assign slot_free = !r_ovalid || i_ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = S_CONV;
            S_CONV: if (n_x == '0) n_state = S_EMIT;
            S_EMIT: if (slot_free && r_idx == '0) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EMIT && slot_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x     <= i_item.value;
                r_radix <= i_item.radix;
                r_cnt   <= '0;
            end
            S_CONV: begin
                r_dig[r_cnt[DIG_AW-1:0]] <= digit;
                r_idx                    <= r_cnt[DIG_AW-1:0];
                r_cnt                    <= r_cnt + 1'b1;
                r_x                      <= n_x;
            end
            S_EMIT: begin
                if (slot_free) begin
                    r_ochar  <= digit_to_ascii(r_dig[r_idx]);
                    r_ocount <= r_cnt;
                    r_olast  <= (r_idx == '0);
                    r_idx    <= r_idx - 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_digit_char  = r_ochar;
    assign o_digit_count = r_ocount;
    assign o_last_digit  = r_olast;

endmodule

// ----- src/bta_checker.sv -----
module bta_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [31:0]                  i_value,
    input logic [1:0]                   i_radix_select,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [bta_pkg::CHAR_W-1:0]   o_digit_char,
    input logic [bta_pkg::COUNT_W-1:0]  o_digit_count,
    input logic                         o_last_digit
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_digit_char))
        else $error("output request dropped or changed while stalled");

    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_digit_char >= 7'd48 && o_digit_char <= 7'd57) ||
                        (o_digit_char >= 7'd65 && o_digit_char <= 7'd70))
        else $error("digit character out of range");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_digit_count >= 6'd1 && o_digit_count <= 6'd32)
        else $error("digit count out of range");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_digit_count == 6'd1 |-> o_last_digit)
        else $error("single digit run not marked last");

    a_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_digit ##1 o_out_valid
        |-> $stable(o_digit_count))
        else $error("digit count changed within a run");

endmodule

bind binary_to_ascii_radix bta_checker u_bta_checker (.*);
